// ----- hw/rtl/urc_pkg.sv -----
`timescale 1ns / 1ps
package urc_pkg;

   localparam int SamplesDef    = 5;
   localparam int TrigPeriodDef = 6000;

   localparam logic [1:0] OP_SCAN  = 2'd0;
   localparam logic [1:0] OP_ECHO  = 2'd1;
   localparam logic [1:0] OP_PULSE = 2'd2;
   localparam logic [1:0] OP_START = 2'd3;

   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_SCALE  = 2'd1;
   localparam logic [1:0] REG_OFFSET = 2'd2;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_ERR       = 3'd1;
   localparam logic [2:0] PH_SUCCESS   = 3'd2;
   localparam logic [2:0] PH_START     = 3'd3;
   localparam logic [2:0] PH_WAIT_RISE = 3'd4;
   localparam logic [2:0] PH_WAIT_FALL = 3'd5;

   localparam logic [15:0] CNT_PERIOD = 16'd65535;
   localparam logic [2:0]  OVF_LIMIT  = 3'd5;
   localparam int          RetrigGap  = 200;
   localparam logic [17:0] SAMPLE_MAX = 18'h3FFFF;
   localparam logic [12:0] HEIGHT_MAX = 13'd8191;

   // request queued from front to back
   typedef struct packed {
      logic [1:0] opcode;
      logic       echo_level;
   } req_type;

   // response fields, highest bit first
   typedef struct packed {
      logic        timeout_error;
      logic        ready_res;
      logic        result_valid;
      logic [12:0] height_tenths_cm;
      logic        trig_level;
   } rsp_type;

endpackage

// ----- hw/rtl/urc_front.sv -----
`timescale 1ns / 1ps
module urc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   output logic              q_valid,
   input  logic              q_ready,
   output urc_pkg::req_type  q_data
);
   import urc_pkg::*;

   // two-entry queue
   req_type    mem_ff [2];
   logic [0:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   req_type    item;

   always_comb begin
      item.opcode     = req_tdata[1:0];
      item.echo_level = req_tdata[2];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_data     = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + 1'(push);
      rp_in  = rp_ff + 1'(pop);
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= item;
   end
endmodule

// ----- hw/rtl/urc_back.sv -----
`timescale 1ns / 1ps
module urc_back #(
   parameter int SAMPLES     = urc_pkg::SamplesDef,
   parameter int TRIG_PERIOD = urc_pkg::TrigPeriodDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  urc_pkg::req_type  q_data,
   input  logic              enable,
   input  logic [23:0]       cm_per_tick_q24,
   input  logic [15:0]       offset_square_cm2,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output urc_pkg::rsp_type  rsp_fields
);
   import urc_pkg::*;

   localparam int IW = $clog2(SAMPLES);
   localparam int MID = (SAMPLES - 1) / 2;
   localparam logic [15:0] TP = 16'(TRIG_PERIOD);
   localparam logic [15:0] RETRIG = 16'(TRIG_PERIOD - RetrigGap);

   // sequencer states
   localparam logic [3:0] S_RUN  = 4'd0;
   localparam logic [3:0] S_M0   = 4'd1;  // ticks * scale, low part
   localparam logic [3:0] S_M1   = 4'd2;  // high part, round
   localparam logic [3:0] S_SQ0  = 4'd3;  // distance squared
   localparam logic [3:0] S_SQ1  = 4'd4;
   localparam logic [3:0] S_SQRT = 4'd5;
   localparam logic [3:0] S_STO  = 4'd6;
   localparam logic [3:0] S_SORT = 4'd7;
   localparam logic [3:0] S_SUM  = 4'd8;
   localparam logic [3:0] S_DIV  = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0]  st_ff;
   logic [2:0]  ph_ff, ph_in;
   logic [15:0] tt_ff, tt_in, pc_ff, pc_in;
   logic [2:0]  oc_ff, oc_in;
   logic [3:0]  sc_ff, sc_in;
   logic        trig_ff, trig_in;
   logic [17:0] store_ff [SAMPLES];
   logic [17:0] srt_ff [SAMPLES];
   logic [18:0] ticks_ff;
   logic [42:0] prod_ff;      // ticks*scale
   logic [42:0] dist_ff;      // Q8 distance
   logic [85:0] sq_ff;
   logic [85:0] rem_ff;       // sqrt remainder
   logic [43:0] root_ff;
   logic [5:0]  it_ff;
   logic [3:0]  pass_ff;
   logic [23:0] sum_ff;
   logic [12:0] h_ff;
   logic        out_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        go_calc;

   assign q_ready    = (st_ff == S_RUN) && !out_ff;
   assign rsp_tvalid = out_ff;
   assign rsp_fields = rsp_ff;

   // event handling for one queued request
   always_comb begin
      ph_in = ph_ff; tt_in = tt_ff; pc_in = pc_ff; oc_in = oc_ff;
      sc_in = sc_ff; trig_in = trig_ff; go_calc = 1'b0;
      case (q_data.opcode)
         OP_SCAN: begin
            if (ph_ff > PH_SUCCESS) begin
               if (tt_ff == 16'd0) trig_in = 1'b1;
               else if (tt_ff == 16'd1) begin
                  trig_in = 1'b0;
                  ph_in   = PH_WAIT_RISE;
               end
               tt_in = tt_ff + 16'd1;
               if (tt_in >= TP) begin
                  tt_in = '0;
                  if (ph_in == PH_WAIT_RISE) begin
                     ph_in = PH_ERR;
                     sc_in = '0;
                  end
               end
            end
         end
         OP_ECHO: begin
            if (q_data.echo_level) begin
               if (ph_ff == PH_WAIT_RISE) begin
                  pc_in = '0; oc_in = '0; ph_in = PH_WAIT_FALL;
               end
            end else if (ph_ff == PH_WAIT_FALL) begin
               ph_in = PH_SUCCESS; tt_in = '0; go_calc = 1'b1;
            end
         end
         OP_PULSE: begin
            if (ph_ff == PH_WAIT_FALL) begin
               pc_in = pc_ff + 16'd1;
               if (pc_in >= CNT_PERIOD) begin
                  pc_in = '0;
                  oc_in = oc_ff + 3'd1;
                  if (oc_in > OVF_LIMIT) begin
                     ph_in = PH_ERR; tt_in = '0; sc_in = '0;
                  end
               end
            end
         end
         default: begin
            if (ph_ff < PH_SUCCESS && enable) begin
               tt_in = '0; sc_in = '0; oc_in = '0; ph_in = PH_START;
            end
         end
      endcase
   end

   always_comb begin
      rsp_in.trig_level       = trig_in;
      rsp_in.height_tenths_cm = '0;
      rsp_in.result_valid     = 1'b0;
      rsp_in.ready_res        = (ph_in < PH_SUCCESS);
      rsp_in.timeout_error    = (ph_in == PH_ERR);
   end

   logic [85:0] trial;
   logic [47:0] pp;
   logic [17:0] hsat;
   logic [27:0] t10;
   logic [31:0] quo;
   always_comb begin
      trial = rem_ff - ({42'd0, root_ff} << (it_ff + 6'd1))
              - (86'd1 << ({1'b0, it_ff} << 1));
      pp    = 48'(ticks_ff[11:0]) * 48'(cm_per_tick_q24);
      hsat  = (root_ff > 44'(SAMPLE_MAX)) ? SAMPLE_MAX : root_ff[17:0];
      t10   = 28'(sum_ff) * 28'd10 + 28'd384;
      quo   = ((32'(t10) >> 8) * 32'd21846) >> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_RUN; ph_ff <= PH_IDLE; tt_ff <= '0; pc_ff <= '0; oc_ff <= '0;
         sc_ff <= '0; trig_ff <= 1'b0; out_ff <= 1'b0;
      end else begin
         if (out_ff && rsp_tready) out_ff <= 1'b0;
         case (st_ff)
            S_RUN: if (q_valid && q_ready) begin
               ph_ff <= ph_in; tt_ff <= tt_in; pc_ff <= pc_in; oc_ff <= oc_in;
               sc_ff <= sc_in; trig_ff <= trig_in;
               rsp_ff <= rsp_in;
               if (go_calc) begin
                  ticks_ff <= 19'(oc_ff * 19'd65535 + 19'(pc_ff));
                  st_ff <= S_M0;
               end else out_ff <= 1'b1;
            end
            S_M0: begin
               prod_ff <= 43'(pp);
               st_ff <= S_M1;
            end
            S_M1: begin
               dist_ff <= 43'((prod_ff + ((43'(ticks_ff[18:12]) * 43'(cm_per_tick_q24)) << 12)
                          + 43'd32768) >> 16);
               st_ff <= S_SQ0;
            end
            S_SQ0: begin
               // 27-bit distance max: split into two partial products
               sq_ff <= 86'(dist_ff[13:0]) * 86'(dist_ff[26:0]);
               st_ff <= S_SQ1;
            end
            S_SQ1: begin
               rem_ff <= 86'(((sq_ff + ((86'(dist_ff[26:14]) * 86'(dist_ff[26:0])) << 14))
                          > ({70'd0, offset_square_cm2} << 16)) ?
                         (sq_ff + ((86'(dist_ff[26:14]) * 86'(dist_ff[26:0])) << 14)
                          - ({70'd0, offset_square_cm2} << 16)) : 86'd0);
               root_ff <= '0;
               it_ff <= 6'd42;
               st_ff <= S_SQRT;
            end
            S_SQRT: begin
               // one result bit a cycle, msb first
               if (!trial[85]) begin
                  rem_ff  <= trial;
                  root_ff <= root_ff | (44'd1 << it_ff);
               end
               if (it_ff == 6'd0) st_ff <= S_STO;
               else it_ff <= it_ff - 6'd1;
            end
            S_STO: begin
               if (sc_ff < 4'(SAMPLES)) store_ff[sc_ff[IW-1:0]] <= hsat;
               if (sc_ff + 4'd1 >= 4'(SAMPLES)) begin
                  for (int i = 0; i < SAMPLES; i++)
                     srt_ff[i] <= (i == int'(sc_ff)) ? hsat : store_ff[i];
                  pass_ff <= '0;
                  st_ff <= S_SORT;
               end else begin
                  sc_ff <= sc_ff + 4'd1;
                  tt_ff <= RETRIG;
                  ph_ff <= PH_START;
                  rsp_ff.ready_res <= 1'b0;
                  out_ff <= 1'b1;
                  st_ff <= S_RUN;
               end
            end
            S_SORT: begin
               // odd-even transposition, one pass a cycle
               for (int i = 0; i + 1 < SAMPLES; i++)
                  if ((i % 2) == int'(pass_ff[0]) && srt_ff[i] > srt_ff[i+1]) begin
                     srt_ff[i]   <= srt_ff[i+1];
                     srt_ff[i+1] <= srt_ff[i];
                  end
               if (pass_ff == 4'(SAMPLES - 1)) st_ff <= S_SUM;
               else pass_ff <= pass_ff + 4'd1;
            end
            S_SUM: begin
               sum_ff <= 24'(srt_ff[MID-1]) + 24'(srt_ff[MID]) + 24'(srt_ff[MID+1]);
               st_ff <= S_DIV;
            end
            S_DIV: begin
               // /768 = >>8 then /3, via reciprocal
               h_ff <= (quo > 32'(HEIGHT_MAX)) ? HEIGHT_MAX : quo[12:0];
               st_ff <= S_OUT;
            end
            default: begin
               rsp_ff.height_tenths_cm <= h_ff;
               rsp_ff.result_valid <= 1'b1;
               rsp_ff.ready_res <= 1'b1;
               rsp_ff.timeout_error <= 1'b0;
               sc_ff <= '0;
               ph_ff <= PH_IDLE;
               out_ff <= 1'b1;
               st_ff <= S_RUN;
            end
         endcase
      end
   end
endmodule

// ----- hw/rtl/ultrasonic_range_controller_top.sv -----
`timescale 1ns / 1ps
// channel  direction  data
// req_     in         tdata[1:0] opcode, [2] echo_level
// rsp_     out        tdata[0] trig, [13:1] height, [14] valid, [15] ready_res, [16] err
// csr_     in         addr: register index, wdata: value
// A request is taken no earlier than the cycle after the previous
// response is taken. A falling echo's response follows the multiply,
// square, bit-serial root and store states; for the last sample of a
// set, the sort, sum and divide states come before it as well.
// Reset is synchronous and active high. A two-entry request queue lets
// the input side keep taking requests while a response waits.
module ultrasonic_range_controller_top #(
   parameter int SAMPLES     = urc_pkg::SamplesDef,
   parameter int TRIG_PERIOD = urc_pkg::TrigPeriodDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // opcode[1:0], echo_level[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // trig_level, height[12:0], valid, ready_res, err
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata
);
   import urc_pkg::*;

   logic        en_ff;
   logic [23:0] scale_ff;
   logic [15:0] off_ff;
   logic        q_valid, q_ready;
   req_type     q_data;
   rsp_type     fields;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b1; scale_ff <= 24'd20372; off_ff <= '0;
      end else if (csr_valid) begin
         case (csr_addr)
            REG_ENABLE: en_ff    <= csr_wdata[0];
            REG_SCALE:  scale_ff <= csr_wdata;
            REG_OFFSET: off_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   urc_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_ready, .q_data
   );

   urc_back #(.SAMPLES(SAMPLES), .TRIG_PERIOD(TRIG_PERIOD)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .enable(en_ff), .cm_per_tick_q24(scale_ff), .offset_square_cm2(off_ff),
      .rsp_tvalid, .rsp_tready, .rsp_fields(fields)
   );

   assign rsp_tdata = {7'd0, fields};
endmodule
